### rtl/cbws_pkg.sv
// cbws_pkg: shared widths, register indexes, command and state types
// for the clipped box window sum block. No dependencies.
`default_nettype none

package cbws_pkg;

	localparam int DEF_MAX_DIM = 128;

	localparam int COORD_W    = 8;
	localparam int POS_W      = 7;
	localparam int SIZE_W     = 8;
	localparam int RADIUS_W   = 7;
	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = CFG_IDX_W'(1);

	localparam logic [SIZE_W-1:0]   RST_MATRIX_SIZE   = SIZE_W'(128);
	localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = RADIUS_W'(1);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// For a write, r_lo/c_lo hold the element position.
	typedef struct packed {
		logic               is_query;
		logic               empty;
		logic               write_ok;
		logic [COORD_W-1:0] r_lo;
		logic [COORD_W-1:0] r_hi;
		logic [COORD_W-1:0] c_lo;
		logic [COORD_W-1:0] c_hi;
		logic [DATA_W-1:0]  value;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN
	} back_state_t;

endpackage

`default_nettype wire

### rtl/clipped_box_window_sum_top.sv
// clipped_box_window_sum_top: configuration registers, front end with
// command queue, back end with element store. Depends on cbws_pkg,
// cbws_front, cbws_back.
//
//   channel  signals                                  direction
//   in       in_valid in_stall action row col value   item in
//   out      out_valid out_stall window_sum           result out
//   cfg      cfg_we cfg_index cfg_data                register write
//
// A write item is stored by the back end while it is idle. A query with a
// clipped window of H rows by W columns reads each element from the store
// once, with an issue step before the reads and a drain step after them. An
// empty window needs no store reads. Two commands queue between front and
// back, so items are taken while a query scans or a result waits. No clearing
// pass after reset; the store holds no data until written.
`default_nettype none

module clipped_box_window_sum_top import cbws_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  action,
	input  wire logic [POS_W-1:0]      row,
	input  wire logic [POS_W-1:0]      col,
	input  wire logic [DATA_W-1:0]     value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [DATA_W-1:0]          window_sum,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIZE_W-1:0]   matrix_size_q;
	logic [RADIUS_W-1:0] window_radius_q;
	logic                cmd_valid, cmd_pop;
	cmd_t                cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q   <= RST_MATRIX_SIZE;
			window_radius_q <= RST_WINDOW_RADIUS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATRIX_SIZE:   matrix_size_q   <= cfg_data[SIZE_W-1:0];
				CFG_WINDOW_RADIUS: window_radius_q <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	cbws_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.row          (row),
		.col          (col),
		.value        (value),
		.matrix_size  (matrix_size_q),
		.window_radius(window_radius_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	cbws_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.window_sum(window_sum)
	);

endmodule

`default_nettype wire

### rtl/cbws_front.sv
// cbws_front: accepts items, clips query windows to the matrix and
// queues commands for the back end. Depends on cbws_pkg.
`default_nettype none

module cbws_front import cbws_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                action,
	input  wire logic [POS_W-1:0]    row,
	input  wire logic [POS_W-1:0]    col,
	input  wire logic [DATA_W-1:0]   value,
	input  wire logic [SIZE_W-1:0]   matrix_size,
	input  wire logic [RADIUS_W-1:0] window_radius,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  wire logic                cmd_pop
);

	logic [SIZE_W-1:0]  size_eff;
	logic [COORD_W-1:0] row_w, col_w, rad_w, smax;
	logic [COORD_W-1:0] r_lo, r_hi, c_lo, c_hi, r_end, c_end;
	cmd_t               new_cmd;
	logic               push;

	cmd_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	always_comb begin
		size_eff = (32'(matrix_size) > MAX_DIM) ? SIZE_W'(MAX_DIM) : matrix_size;
		row_w    = COORD_W'(row);
		col_w    = COORD_W'(col);
		rad_w    = COORD_W'(window_radius);
		smax     = COORD_W'(size_eff) - COORD_W'(1);
		r_lo     = (row_w > rad_w) ? row_w - rad_w : '0;
		c_lo     = (col_w > rad_w) ? col_w - rad_w : '0;
		r_end    = row_w + rad_w;
		c_end    = col_w + rad_w;
		r_hi     = (r_end > smax) ? smax : r_end;
		c_hi     = (c_end > smax) ? smax : c_end;

		new_cmd.is_query = (action == ACT_QUERY);
		new_cmd.empty    = (size_eff == '0) || (r_lo > r_hi) || (c_lo > c_hi);
		new_cmd.write_ok = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
		new_cmd.value    = value;
		new_cmd.r_hi     = r_hi;
		new_cmd.c_hi     = c_hi;
		if (action == ACT_QUERY) begin
			new_cmd.r_lo = r_lo;
			new_cmd.c_lo = c_lo;
		end else begin
			new_cmd.r_lo = row_w;
			new_cmd.c_lo = col_w;
		end
	end

	assign in_stall  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/cbws_back.sv
// cbws_back: element store, window scan sequencer, accumulator and
// output register. Depends on cbws_pkg.
`default_nettype none

module cbws_back import cbws_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  cmd_t                   cmd,
	output logic                   cmd_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      window_sum
);

	localparam int DW = $clog2(MAX_DIM);
	localparam int AW = 2 * DW;

	back_state_t        state_q, state_d;
	logic [COORD_W-1:0] i_q, j_q, r_hi_q, c_lo_q, c_hi_q;
	logic [DATA_W-1:0]  acc_q, sum_q, load_data, rdata_s1;
	logic               rd_s1, out_valid_q;
	logic               out_free, out_load, start, rd_en, mem_we, last_issue;
	logic [AW-1:0]      waddr, raddr;

	logic [DATA_W-1:0]  mem [2**AW];

	assign out_free   = !out_valid_q || !out_stall;
	assign last_issue = (i_q == r_hi_q) && (j_q == c_hi_q);
	assign waddr      = {DW'(cmd.r_lo), DW'(cmd.c_lo)};
	assign raddr      = {DW'(i_q), DW'(j_q)};

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		start     = 1'b0;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		load_data = '0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.is_query) begin
						cmd_pop = 1'b1;
						mem_we  = cmd.write_ok;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						if (cmd.empty) begin
							out_load = 1'b1;
						end else begin
							start   = 1'b1;
							state_d = BK_SCAN;
						end
					end
				end
			end
			BK_SCAN: begin
				rd_en = 1'b1;
				if (last_issue) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				out_load  = 1'b1;
				load_data = acc_q + rdata_s1;
				state_d   = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= cmd.value;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q    <= cmd.r_lo;
			j_q    <= cmd.c_lo;
			r_hi_q <= cmd.r_hi;
			c_lo_q <= cmd.c_lo;
			c_hi_q <= cmd.c_hi;
			acc_q  <= '0;
		end else begin
			if (rd_en) begin
				if (j_q == c_hi_q) begin
					j_q <= c_lo_q;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (rd_s1) begin
				acc_q <= acc_q + rdata_s1;
			end
		end
		if (out_load) begin
			sum_q <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign window_sum = sum_q;

`ifndef SYNTHESIS
	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DRAIN |-> rd_s1)
		else $error("drain without pending read");
	a_scan_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> (i_q <= r_hi_q && j_q <= c_hi_q && j_q >= c_lo_q))
		else $error("scan index out of window");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");
	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == BK_IDLE && !rd_s1))
		else $error("store write during scan");
	a_scan_reads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |=> rd_s1)
		else $error("scan cycle issued no read");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for clipped_box_window_sum_top: directed item table, then
// randomized write/query traffic across several register settings with bursty input and
// random output stall. Depends on cbws_pkg and the block RTL.
`timescale 1ns / 1ps

module testbench;
	import cbws_pkg::*;

	localparam int DIM        = DEF_MAX_DIM;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_PHASES   = 10;
	localparam int N_DIRECTED = 15;

	typedef struct packed {
		logic              act;
		logic [POS_W-1:0]  r;
		logic [POS_W-1:0]  c;
		logic [DATA_W-1:0] v;
		logic              typed;
		logic [DATA_W-1:0] sum;
	} stim_row_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  action     = ACT_WRITE;
	logic [POS_W-1:0]      row        = '0;
	logic [POS_W-1:0]      col        = '0;
	logic [DATA_W-1:0]     value      = '0;
	logic                  out_stall  = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MATRIX_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_stall;
	logic                  out_valid;
	logic [DATA_W-1:0]     window_sum;

	// local copy of block state
	logic [DATA_W-1:0] elem_mem   [0:DIM-1][0:DIM-1];
	bit                elem_known [0:DIM-1][0:DIM-1];
	int                cur_size   = RST_MATRIX_SIZE;
	int                cur_radius = RST_WINDOW_RADIUS;

	logic [DATA_W-1:0] pending_sums[$];
	int                errors      = 0;
	int                burst_left  = 0;
	int                idle_cycles = 0;
	int                stall_mode  = 0;
	int                stall_run   = 0;

	int ph_size   [0:N_PHASES-1] = '{8, 1, 0, 16, 5, 200, 128, 12, 3, 255};
	int ph_radius [0:N_PHASES-1] = '{1, 0, 3, 2, 127, 1, 0, 3, 9, 2};
	int ph_items  [0:N_PHASES-1] = '{40, 30, 20, 30, 30, 14, 30, 40, 40, 6};

	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{ACT_WRITE, 7'd0,   7'd0,   16'hFFFF, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd0,   7'd1,   16'hFFFF, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd1,   7'd0,   16'hFFFF, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd1,   7'd1,   16'hFFFF, 1'b0, 16'h0000},
		'{ACT_QUERY, 7'd0,   7'd0,   16'hFFFF, 1'b1, 16'hFFFC},
		'{ACT_WRITE, 7'd127, 7'd127, 16'h0001, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd126, 7'd127, 16'h0002, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd127, 7'd126, 16'h0004, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd126, 7'd126, 16'h8000, 1'b0, 16'h0000},
		'{ACT_QUERY, 7'd127, 7'd127, 16'h0000, 1'b1, 16'h8007},
		'{ACT_WRITE, 7'd0,   7'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_QUERY, 7'd0,   7'd0,   16'h1234, 1'b1, 16'hFFFD},
		'{ACT_WRITE, 7'd0,   7'd2,   16'h1234, 1'b0, 16'h0000},
		'{ACT_WRITE, 7'd1,   7'd2,   16'h0001, 1'b0, 16'h0000},
		'{ACT_QUERY, 7'd0,   7'd1,   16'h0000, 1'b0, 16'h0000}
	};

	clipped_box_window_sum_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.row        (row),
		.col        (col),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_sum (window_sum),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_size();
		return (cur_size > DIM) ? DIM : cur_size;
	endfunction

	// returns 1 when nothing of the window lies inside the matrix
	function automatic bit clip_window(input int r, input int c, output int rlo,
			output int rhi, output int clo, output int chi);
		int s;
		s   = eff_size();
		rlo = (r > cur_radius) ? r - cur_radius : 0;
		clo = (c > cur_radius) ? c - cur_radius : 0;
		rhi = (r + cur_radius > s - 1) ? s - 1 : r + cur_radius;
		chi = (c + cur_radius > s - 1) ? s - 1 : c + cur_radius;
		return (s == 0) || (rlo > rhi) || (clo > chi);
	endfunction

	function automatic logic [DATA_W-1:0] box_total(input int r, input int c);
		int rlo, rhi, clo, chi;
		logic [DATA_W-1:0] acc;
		acc = '0;
		if (!clip_window(r, c, rlo, rhi, clo, chi)) begin
			for (int i = rlo; i <= rhi; i++)
				for (int j = clo; j <= chi; j++)
					acc = acc + elem_mem[i][j];
		end
		return acc;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_item(input logic act, input int r, input int c,
			input logic [DATA_W-1:0] v, input bit typed, input logic [DATA_W-1:0] typed_sum);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		action   <= act;
		row      <= POS_W'(r);
		col      <= POS_W'(c);
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		if (act == ACT_WRITE) begin
			elem_mem[r][c]   = v;
			elem_known[r][c] = 1'b1;
		end else begin
			pending_sums.push_back(typed ? typed_sum : box_total(r, c));
		end
		burst_left--;
		@(negedge clk);
	endtask

	// write every element the window would read that has no value yet
	task automatic cover_window(input int r, input int c);
		int rlo, rhi, clo, chi;
		if (!clip_window(r, c, rlo, rhi, clo, chi)) begin
			for (int i = rlo; i <= rhi; i++)
				for (int j = clo; j <= chi; j++)
					if (!elem_known[i][j])
						push_item(ACT_WRITE, i, j, DATA_W'($urandom), 1'b0, '0);
		end
	endtask

	task automatic query_at(input int r, input int c);
		cover_window(r, c);
		push_item(ACT_QUERY, r, c, DATA_W'($urandom), 1'b0, '0);
	endtask

	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		if (idx == CFG_MATRIX_SIZE)
			cur_size = data & 8'hFF;
		else if (idx == CFG_WINDOW_RADIUS)
			cur_radius = data & 7'h7F;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(2);
			stall_run  = $urandom_range(8, 64);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(1) == 1);
			default: out_stall <= ($urandom_range(3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_sums.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, window_sum);
					errors++;
				end else if (window_sum !== pending_sums[0]) begin
					$display("%0t: window_sum mismatch, expected %h, got %h",
						$time, pending_sums[0], window_sum);
					errors++;
					void'(pending_sums.pop_front());
				end else begin
					void'(pending_sums.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $time, pending_sums.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int s, span_w, span_q, r, c;
		logic [DATA_W-1:0] v;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < N_DIRECTED; k++)
			push_item(directed_rows[k].act, directed_rows[k].r, directed_rows[k].c,
				directed_rows[k].v, directed_rows[k].typed, directed_rows[k].sum);

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			set_reg(CFG_MATRIX_SIZE, ph_size[p]);
			set_reg(CFG_WINDOW_RADIUS, ph_radius[p]);
			if (p % 3 == 1)
				set_reg(CFG_IDX_W'($urandom_range(2, 15)), $urandom_range(255));
			s      = eff_size();
			span_w = (s > DIM - 1) ? DIM - 1 : s;
			span_q = (s + cur_radius > DIM - 1) ? DIM - 1 : s + cur_radius;

			// raster sweep: full box-filtered matrix for sizes up to 8
			if (s > 0 && s <= 8)
				for (int i = 0; i < s; i++)
					for (int j = 0; j < s; j++)
						query_at(i, j);

			for (int n = 0; n < ph_items[p]; n++) begin
				if ($urandom_range(99) < 35) begin
					r = ($urandom_range(9) < 8) ? $urandom_range(span_w) : $urandom_range(DIM - 1);
					c = ($urandom_range(9) < 8) ? $urandom_range(span_w) : $urandom_range(DIM - 1);
					if ($urandom_range(4) == 0)
						v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					else
						v = DATA_W'($urandom);
					push_item(ACT_WRITE, r, c, v, 1'b0, '0);
				end else begin
					r = ($urandom_range(3) != 0) ? $urandom_range(span_q) : $urandom_range(DIM - 1);
					c = ($urandom_range(3) != 0) ? $urandom_range(span_q) : $urandom_range(DIM - 1);
					query_at(r, c);
				end
			end
		end

		settle();
		repeat (40) @(negedge clk);
		if (errors == 0 && pending_sums.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
